>>> hw/rtl/qri_pkg.sv
package qri_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int RATE_FRAC = 12;
   localparam int DT_FRAC = 16;
   // The extra bit accounts for the factor one half in the kinematic equation.
   localparam int INC_SHIFT = RATE_FRAC + DT_FRAC + 1;

   localparam logic [15:0] STEP_TIME_RESET = 16'd1311;
   localparam logic [15:0] OUT_ONE = 16'(1 << 14);

   localparam logic ACT_INTEGRATE = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   localparam int NUM_TERMS = 12;

   // One product of a quaternion component and a body rate; last marks the end of a derivative.
   typedef struct packed {
      logic [1:0] comp;
      logic [1:0] rate;
      logic       neg;
      logic       last;
   } term_type;

   localparam term_type TERM_TABLE [NUM_TERMS] = '{
      '{2'd1, 2'd0, 1'b1, 1'b0}, '{2'd2, 2'd1, 1'b1, 1'b0}, '{2'd3, 2'd2, 1'b1, 1'b1},
      '{2'd0, 2'd0, 1'b0, 1'b0}, '{2'd2, 2'd2, 1'b0, 1'b0}, '{2'd3, 2'd1, 1'b1, 1'b1},
      '{2'd0, 2'd1, 1'b0, 1'b0}, '{2'd1, 2'd2, 1'b1, 1'b0}, '{2'd3, 2'd0, 1'b0, 1'b1},
      '{2'd0, 2'd2, 1'b0, 1'b0}, '{2'd1, 2'd1, 1'b0, 1'b0}, '{2'd2, 2'd0, 1'b1, 1'b1}
   };

endpackage

>>> hw/rtl/qri_mul.sv
module qri_mul #(
   parameter int A_BITS = 34,
   parameter int B_BITS = 17
) (
   input  logic                              clock,
   input  logic signed [A_BITS-1:0]          mul_a,
   input  logic signed [B_BITS-1:0]          mul_b,
   output logic signed [A_BITS+B_BITS-1:0]   prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

>>> hw/rtl/qri_isqrt.sv
module qri_isqrt #(
   parameter int W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [W-1:0]     radicand,
   output logic             done_ff,
   output logic [W/2-1:0]   root
);

   localparam int KW = $clog2(W/2);

   logic [W-1:0]  rem_ff;
   logic [W-1:0]  r_ff;
   logic [KW-1:0] k_ff;
   logic          busy_ff;
   logic [W-1:0]  bit_val;
   logic [W:0]    trial;

   assign bit_val = W'(1) << {k_ff, 1'b0};
   assign trial = {1'b0, r_ff} + {1'b0, bit_val};
   assign root = r_ff[W/2-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= radicand;
            r_ff <= '0;
            k_ff <= KW'(W/2 - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_ff <= rem_ff - trial[W-1:0];
               r_ff <= (r_ff >> 1) + bit_val;
            end else begin
               r_ff <= r_ff >> 1;
            end
            k_ff <= k_ff - KW'(1);
            if (k_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> hw/rtl/qri_div.sv
module qri_div #(
   parameter int NB = 32,
   parameter int DB = 17,
   parameter int QB = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NB-1:0]  num,
   input  logic [DB-1:0]  den,
   output logic           done_ff,
   output logic [QB-1:0]  quo
);

   localparam int CW = $clog2(QB);

   logic [DB-1:0] rem_ff;
   logic [QB-1:0] q_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [DB:0]   t;
   logic          ge;

   // The caller guarantees the high part of the numerator is below the divisor.
   assign t = {rem_ff, q_ff[QB-1]};
   assign ge = t >= {1'b0, den};
   assign quo = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= DB'(num >> QB);
            q_ff <= num[QB-1:0];
            cnt_ff <= CW'(QB - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? DB'(t - {1'b0, den}) : DB'(t);
            q_ff <= {q_ff[QB-2:0], ge};
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> hw/rtl/quaternion_rate_integrator.sv
// Attitude quaternion integrator with renormalization.
// Input channel (req_*): one item per transfer. An integrate item (action 0)
// advances the attitude by half of Omega(rates) times the quaternion times
// step_time; a load item (action 1) sets the attitude from the load fields.
// Either way the new attitude is divided by its norm and sent as one result
// on the rsp_* channel. A zero norm restores identity and sets norm_zero.
// Datapath: one registered multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider run in sequence; the divider, which computes
// the four normalized components one after another, dominates the time
// from transfer in to result valid. req_ready is high only while idle, so
// a new item is taken only after the previous one has reached the output
// register.
// The result sits in an output register, so the next item is taken while
// the previous result waits; a receiver that stalls longer holds the block
// at its last step until the result register is free.
// Reset gives the identity attitude and step_time 1311; csr writes take
// effect at once and belong only in idle periods.
module quaternion_rate_integrator import qri_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [15:0] req_roll_rate,
   input  logic signed [15:0] req_pitch_rate,
   input  logic signed [15:0] req_yaw_rate,
   input  logic signed [15:0] req_load_w,
   input  logic signed [15:0] req_load_x,
   input  logic signed [15:0] req_load_y,
   input  logic signed [15:0] req_load_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_w,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_norm_zero,
   input  logic               csr_write_en,
   input  logic [15:0]        csr_write_data
);

   localparam int CB = COMPONENT_BITS;
   localparam int FB = CB - 2;
   localparam int AW = CB + 18;
   localparam int BW = (CB + 1 > 17) ? CB + 1 : 17;
   localparam int PW = AW + BW;
   localparam int IW = CB + 6;
   localparam int SW = 2 * CB + 1;
   localparam int SQW = (SW > 64) ? 64 : SW;
   localparam int EW = SQW + (SQW % 2);
   localparam int RW = EW / 2;
   localparam int NB = 2 * CB;
   localparam int QB = CB;
   localparam int SHR = (CB >= 16) ? CB - 16 : 0;
   localparam int SHL = (CB < 16) ? 16 - CB : 0;

   localparam logic signed [CB-1:0] ONE_C = CB'(64'd1 << FB);
   localparam logic signed [IW-1:0] CMAX_W = IW'((64'd1 << (CB - 1)) - 64'd1);
   localparam logic signed [IW-1:0] CMIN_W = ~CMAX_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_STEP, ST_UPD, ST_SQ, ST_SQACC,
      ST_ROOTGO, ST_ROOT, ST_DIVGO, ST_DIVW, ST_OUT
   } state_type;

   state_type               state_ff;
   logic signed [CB-1:0]    att_ff [4];
   logic signed [CB-1:0]    c_ff [4];
   logic signed [15:0]      rate_ff [3];
   logic [15:0]             step_ff;
   logic signed [AW-1:0]    acc_ff;
   logic [SW-1:0]           sum_ff;
   logic [3:0]              cnt_ff;
   logic [1:0]              j_ff;
   logic                    flag_ff;
   logic                    rsp_valid_ff;
   logic signed [15:0]      out_w_ff, out_x_ff, out_y_ff, out_z_ff;
   logic                    out_zero_ff;

   logic signed [AW-1:0]    mul_a;
   logic signed [BW-1:0]    mul_b;
   logic signed [PW-1:0]    prod_ff;
   term_type                term;
   logic signed [AW-1:0]    prod_t;
   logic signed [AW-1:0]    acc_mag;
   logic [PW-1:0]           rounded;
   logic [IW-1:0]           inc_t;
   logic signed [IW-1:0]    inc_s;
   logic signed [IW-1:0]    upd_sum;
   logic [SQW-1:0]          s_clamp;
   logic                    sq_start, sq_done;
   logic [RW-1:0]           sq_root;
   logic [CB-1:0]           c_mag;
   logic [NB-1:0]           div_num;
   logic                    div_start, div_done;
   logic [QB-1:0]           div_quo;

   function automatic logic signed [CB-1:0] sat_c(input logic signed [IW-1:0] v);
      if (v > CMAX_W) begin
         return CMAX_W[CB-1:0];
      end else if (v < CMIN_W) begin
         return CMIN_W[CB-1:0];
      end
      return v[CB-1:0];
   endfunction

   function automatic logic signed [15:0] to_out(input logic signed [CB-1:0] v);
      logic signed [47:0] wide;
      wide = 48'(v);
      if (CB >= 16) begin
         return 16'(wide >>> SHR);
      end
      return 16'(wide <<< SHL);
   endfunction

   assign term = TERM_TABLE[cnt_ff];
   assign prod_t = prod_ff[AW-1:0];
   assign acc_mag = acc_ff[AW-1] ? -acc_ff : acc_ff;
   assign rounded = $unsigned(prod_ff) + PW'(64'd1 << (INC_SHIFT - 1));
   assign inc_t = IW'(rounded >> INC_SHIFT);
   assign inc_s = acc_ff[AW-1] ? -$signed(inc_t) : $signed(inc_t);
   assign upd_sum = IW'(att_ff[j_ff]) + inc_s;
   // The sum of squares can only pass 64 bits when COMPONENT_BITS is 32 or more.
   assign s_clamp = ((sum_ff >> SQW) != '0) ? '1 : SQW'(sum_ff);
   assign c_mag = c_ff[j_ff][CB-1] ? CB'(-c_ff[j_ff]) : CB'(c_ff[j_ff]);
   assign div_num = (NB'(c_mag) << FB) + NB'(sq_root >> 1);
   assign sq_start = (state_ff == ST_ROOTGO) && (sum_ff != '0);
   assign div_start = (state_ff == ST_DIVGO);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            mul_a = AW'(att_ff[term.comp]);
            mul_b = BW'(rate_ff[term.rate]);
         end
         ST_STEP: begin
            mul_a = acc_mag;
            mul_b = BW'($signed({1'b0, step_ff}));
         end
         ST_SQ: begin
            mul_a = AW'(c_ff[j_ff]);
            mul_b = BW'(c_ff[j_ff]);
         end
         default: begin
         end
      endcase
   end

   qri_mul #(.A_BITS(AW), .B_BITS(BW)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   qri_isqrt #(.W(EW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (EW'(s_clamp)),
      .done_ff  (sq_done),
      .root     (sq_root)
   );

   qri_div #(.NB(NB), .DB(RW), .QB(QB)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (sq_root),
      .done_ff (div_done),
      .quo     (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         att_ff[0] <= ONE_C;
         att_ff[1] <= '0;
         att_ff[2] <= '0;
         att_ff[3] <= '0;
         step_ff <= STEP_TIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            step_ff <= csr_write_data;
         end
         // The output step sets valid itself, including when a transfer frees the register.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sum_ff <= '0;
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  j_ff <= '0;
                  flag_ff <= 1'b0;
                  rate_ff[0] <= req_roll_rate;
                  rate_ff[1] <= req_pitch_rate;
                  rate_ff[2] <= req_yaw_rate;
                  if (req_action == ACT_LOAD) begin
                     c_ff[0] <= sat_c(IW'(req_load_w));
                     c_ff[1] <= sat_c(IW'(req_load_x));
                     c_ff[2] <= sat_c(IW'(req_load_y));
                     c_ff[3] <= sat_c(IW'(req_load_z));
                     state_ff <= ST_SQ;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= term.neg ? acc_ff - prod_t : acc_ff + prod_t;
               cnt_ff <= cnt_ff + 4'd1;
               state_ff <= term.last ? ST_STEP : ST_MUL;
            end
            ST_STEP: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               c_ff[j_ff] <= sat_c(upd_sum);
               acc_ff <= '0;
               j_ff <= j_ff + 2'd1;
               state_ff <= (j_ff == 2'd3) ? ST_SQ : ST_MUL;
            end
            ST_SQ: begin
               state_ff <= ST_SQACC;
            end
            ST_SQACC: begin
               sum_ff <= sum_ff + SW'($unsigned(prod_ff));
               j_ff <= j_ff + 2'd1;
               state_ff <= (j_ff == 2'd3) ? ST_ROOTGO : ST_SQ;
            end
            ST_ROOTGO: begin
               if (sum_ff == '0) begin
                  att_ff[0] <= ONE_C;
                  att_ff[1] <= '0;
                  att_ff[2] <= '0;
                  att_ff[3] <= '0;
                  flag_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (sq_done) begin
                  state_ff <= ST_DIVGO;
               end
            end
            ST_DIVGO: begin
               state_ff <= ST_DIVW;
            end
            ST_DIVW: begin
               if (div_done) begin
                  att_ff[j_ff] <= c_ff[j_ff][CB-1] ? -$signed(div_quo) : $signed(div_quo);
                  j_ff <= j_ff + 2'd1;
                  state_ff <= (j_ff == 2'd3) ? ST_OUT : ST_DIVGO;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  out_w_ff <= to_out(att_ff[0]);
                  out_x_ff <= to_out(att_ff[1]);
                  out_y_ff <= to_out(att_ff[2]);
                  out_z_ff <= to_out(att_ff[3]);
                  out_zero_ff <= flag_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_w = out_w_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;
   assign rsp_norm_zero = out_zero_ff;

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_identity_on_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_norm_zero |-> rsp_out_w == OUT_ONE && rsp_out_x == '0
         && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("zero norm result is not the identity");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");
`endif

endmodule

>>> dv/quaternion_rate_integrator_tb.sv
module quaternion_rate_integrator_tb import qri_pkg::*;;

   typedef struct {
      logic        action;
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
      logic [15:0] lw;
      logic [15:0] lx;
      logic [15:0] ly;
      logic [15:0] lz;
   } cmd_type;

   typedef struct {
      logic [15:0] w;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic        nz;
   } attitude_type;

   class attitude_scoreboard_type;
      longint        att [4];
      longint        step_time;
      attitude_type  pending [$];
      int            errors;
      int            checked;

      function new();
         att[0] = 64'sd16384;
         att[1] = 0;
         att[2] = 0;
         att[3] = 0;
         step_time = STEP_TIME_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function longint clamp16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint scaled_increment(longint d);
         longint m;
         longint r;
         m = (d < 0) ? -d : d;
         r = (m * step_time + (64'sd1 << (INC_SHIFT - 1))) >>> INC_SHIFT;
         return (d < 0) ? -r : r;
      endfunction

      function longint int_sqrt(longint s);
         longint r;
         longint b;
         r = 0;
         b = 64'sd1 << 40;
         while (b > s) b = b >>> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      function void note_command(cmd_type c);
         longint       v [4];
         longint       d [4];
         longint       p, q, r, s, n, m, qv;
         attitude_type e;
         int           i;
         if (c.action == ACT_LOAD) begin
            v[0] = longint'($signed(c.lw));
            v[1] = longint'($signed(c.lx));
            v[2] = longint'($signed(c.ly));
            v[3] = longint'($signed(c.lz));
         end else begin
            p = longint'($signed(c.roll));
            q = longint'($signed(c.pitch));
            r = longint'($signed(c.yaw));
            d[0] = -att[1] * p - att[2] * q - att[3] * r;
            d[1] = att[0] * p + att[2] * r - att[3] * q;
            d[2] = att[0] * q - att[1] * r + att[3] * p;
            d[3] = att[0] * r + att[1] * q - att[2] * p;
            for (i = 0; i < 4; i++) v[i] = clamp16(att[i] + scaled_increment(d[i]));
         end
         s = 0;
         for (i = 0; i < 4; i++) s += v[i] * v[i];
         if (s == 0) begin
            att[0] = 16384;
            att[1] = 0;
            att[2] = 0;
            att[3] = 0;
            e.nz = 1'b1;
         end else begin
            n = int_sqrt(s);
            for (i = 0; i < 4; i++) begin
               m = (v[i] < 0) ? -v[i] : v[i];
               qv = ((m << 14) + (n >>> 1)) / n;
               if (qv > 32768) qv = 32768;
               att[i] = clamp16((v[i] < 0) ? -qv : qv);
            end
            e.nz = 1'b0;
         end
         e.w = att[0][15:0];
         e.x = att[1][15:0];
         e.y = att[2][15:0];
         e.z = att[3][15:0];
         pending.push_back(e);
      endfunction

      function void check_result(attitude_type a);
         attitude_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                     $signed(a.w), $signed(a.x), $signed(a.y), $signed(a.z));
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.w !== e.w) begin
            $display("%0t: out_w expected %0d actual %0d", $time, $signed(e.w), $signed(a.w));
            errors++;
         end
         if (a.x !== e.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, $signed(e.x), $signed(a.x));
            errors++;
         end
         if (a.y !== e.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, $signed(e.y), $signed(a.y));
            errors++;
         end
         if (a.z !== e.z) begin
            $display("%0t: out_z expected %0d actual %0d", $time, $signed(e.z), $signed(a.z));
            errors++;
         end
         if (a.nz !== e.nz) begin
            $display("%0t: norm_zero expected %0b actual %0b", $time, e.nz, a.nz);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = 1'b0;
   logic signed [15:0] req_roll_rate = '0;
   logic signed [15:0] req_pitch_rate = '0;
   logic signed [15:0] req_yaw_rate = '0;
   logic signed [15:0] req_load_w = '0;
   logic signed [15:0] req_load_x = '0;
   logic signed [15:0] req_load_y = '0;
   logic signed [15:0] req_load_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_w;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;
   logic               rsp_norm_zero;
   logic               csr_write_en = 1'b0;
   logic [15:0]        csr_write_data = '0;

   attitude_scoreboard_type sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   int  sent = 0;
   int  loads = 0;
   longint cycles = 0;

   quaternion_rate_integrator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_roll_rate(req_roll_rate), .req_pitch_rate(req_pitch_rate),
      .req_yaw_rate(req_yaw_rate), .req_load_w(req_load_w), .req_load_x(req_load_x),
      .req_load_y(req_load_y), .req_load_z(req_load_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_w(rsp_out_w),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_norm_zero(rsp_norm_zero),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver side: randomly stalls, and holds off completely on request.
   always @(posedge clock) begin
      attitude_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         a.w = rsp_out_w;
         a.x = rsp_out_x;
         a.y = rsp_out_y;
         a.z = rsp_out_z;
         a.nz = rsp_norm_zero;
         sb.check_result(a);
      end
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         cmd_type c;
         c.action = req_action;
         c.roll = req_roll_rate;
         c.pitch = req_pitch_rate;
         c.yaw = req_yaw_rate;
         c.lw = req_load_w;
         c.lx = req_load_x;
         c.ly = req_load_y;
         c.lz = req_load_z;
         sb.note_command(c);
      end
   end

   // Valid stays high after a transfer so the next item can follow at once;
   // callers drop it when a batch ends.
   task automatic send_item(cmd_type c);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= c.action;
      req_roll_rate <= c.roll;
      req_pitch_rate <= c.pitch;
      req_yaw_rate <= c.yaw;
      req_load_w <= c.lw;
      req_load_x <= c.lx;
      req_load_y <= c.ly;
      req_load_z <= c.lz;
      @(posedge clock iff req_ready);
      sent++;
      if (c.action == ACT_LOAD) loads++;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cmd_type random_item(bit force_load);
      cmd_type c;
      c.action = force_load || ($urandom_range(9) < 2);
      c.roll = pick_value();
      c.pitch = pick_value();
      c.yaw = pick_value();
      c.lw = pick_value();
      c.lx = pick_value();
      c.ly = pick_value();
      c.lz = pick_value();
      // Now and then all-zero load fields, to hit the identity restore when the item is a load.
      if ($urandom_range(30) == 0) begin
         c.lw = '0;
         c.lx = '0;
         c.ly = '0;
         c.lz = '0;
      end
      return c;
   endfunction

   task automatic drain();
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_step_time(logic [15:0] v);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.step_time = v;
   endtask

   task automatic directed_items();
      cmd_type c;
      logic [15:0] ext [4];
      ext = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001};
      for (int i = 0; i < 4; i++) begin
         c = random_item(1'b1);
         c.lw = ext[i];
         c.lx = ext[(i + 1) % 4];
         c.ly = ext[(i + 2) % 4];
         c.lz = ext[(i + 3) % 4];
         send_item(c);
      end
      c = random_item(1'b1);
      c.lw = '0; c.lx = '0; c.ly = '0; c.lz = '0;
      send_item(c);
      for (int i = 0; i < 6; i++) begin
         c = random_item(1'b0);
         c.action = ACT_INTEGRATE;
         c.roll = ext[i % 4];
         c.pitch = ext[(i + 1) % 4];
         c.yaw = ext[(i + 2) % 4];
         send_item(c);
      end
      c = random_item(1'b1);
      c.lw = 16'h8000; c.lx = 16'h8000; c.ly = 16'h8000; c.lz = 16'h8000;
      send_item(c);
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] steps [5];
      int pct [4][2];
      steps = '{16'hffff, 16'h0000, 16'd1311, 16'h8000, 16'd40000};
      pct = '{'{0, 0}, '{82, 0}, '{0, 82}, '{6, 6}};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      drain();

      // Hold the receiver off while items keep coming, so the block backs up.
      fork
         begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) send_item(random_item(1'b0));
            req_valid <= 1'b0;
         end
      join
      drain();

      for (int s = 0; s < 5; s++) begin
         write_step_time(steps[s]);
         for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = pct[ph][0];
            recv_stall_pct = pct[ph][1];
            for (int i = 0; i < 96; i++) send_item(random_item(1'b0));
         end
         req_valid <= 1'b0;
         send_idle_pct = 0;
         recv_stall_pct = 0;
         drain();
      end

      $display("Sent %0d items (%0d loads), checked %0d results over five step times.",
               sent, loads, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/qri_pkg.sv
hw/rtl/qri_mul.sv
hw/rtl/qri_isqrt.sv
hw/rtl/qri_div.sv
hw/rtl/quaternion_rate_integrator.sv
dv/quaternion_rate_integrator_tb.sv
